@@ rtl/sm83_cpu_core_subset_core_defines.svh @@
// Assertion macros for the SM83 core subset.
// Used by sm83_cpu_core_subset_core; needs signals clk and rst_n in scope.
`ifndef SM83_CPU_CORE_SUBSET_CORE_DEFINES_SVH
`define SM83_CPU_CORE_SUBSET_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("lbl failed");
`define SM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("lbl failed");
`else
`define SM_ASSERT(lbl, prop)
`define SM_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ rtl/sm83_pkg.sv @@
// Types, codes and ALU functions for the SM83 core subset.
// No dependencies.
package sm83_pkg;
  localparam logic [1:0] BK_READ  = 2'd0;
  localparam logic [1:0] BK_WRITE = 2'd1;
  localparam logic [1:0] BK_STOP  = 2'd2;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_OPCODE = 3'd1;
  localparam logic [2:0] PH_BYTE1  = 3'd2;
  localparam logic [2:0] PH_BYTE2  = 3'd3;
  localparam logic [2:0] PH_MEM    = 3'd4;

  localparam logic [4:0] SH_LEGAL = 5'h10;
  localparam logic [4:0] SH_MEM   = 5'h08;
  localparam logic [4:0] SH_SP    = 5'h04;

  localparam logic [15:0] START_DEFAULT = 16'h0000;
  localparam int QDEPTH = 4;

  typedef logic [5:0][7:0] regs_t;

  typedef struct packed {
    logic [7:0] r;
    logic [3:0] f;
  } alu_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  wbyte;
    logic        done;
    logic [4:0]  cyc;
    logic        last;
  } res_t;

  function automatic logic [4:0] shape(logic [7:0] op);
    case (op) inside
      8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h3E, 8'h18, 8'h20, 8'h28, 8'h30,
      8'h38, 8'hC6, 8'hCE, 8'hD6, 8'hE6, 8'hEE, 8'hFE, 8'hE0, 8'hE8, 8'hF8:
        shape = SH_LEGAL | 5'd1;
      8'hF0: shape = SH_LEGAL | SH_MEM | 5'd1;
      8'h01, 8'h11, 8'h21, 8'h31, 8'h08, 8'hC2, 8'hC3, 8'hC4, 8'hCD, 8'hEA:
        shape = SH_LEGAL | 5'd2;
      8'hFA: shape = SH_LEGAL | SH_MEM | 5'd2;
      8'hC1, 8'hD1, 8'hE1, 8'hF1, 8'hC9, 8'hC8, 8'hD0, 8'hD8:
        shape = SH_LEGAL | SH_SP | 5'd2;
      8'h1A, 8'h2A, 8'h35, 8'h46, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6E, 8'h7E, 8'h86,
      8'hAE, 8'hB6, 8'hBE:
        shape = SH_LEGAL | SH_MEM;
      8'h00, 8'h03, 8'h04, 8'h05, 8'h0C, 8'h0D, 8'h12, 8'h13, 8'h14, 8'h15, 8'h17,
      8'h1C, 8'h1D, 8'h1F, 8'h22, 8'h23, 8'h24, 8'h25, 8'h27, 8'h29, 8'h2C, 8'h2D,
      8'h32, 8'h33, 8'h39, 8'h3B, 8'h3C, 8'h3D, 8'h47, 8'h4F, 8'h57, 8'h5D, 8'h5F,
      8'h62, 8'h67, 8'h6B, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h77, 8'h78, 8'h79,
      8'h7A, 8'h7B, 8'h7C, 8'h7D, 8'h80, 8'h90, 8'hA9, 8'hAD, 8'hAF, 8'hB0, 8'hB1,
      8'hB7, 8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hC5, 8'hD5, 8'hE5, 8'hF5, 8'hE2, 8'hE9,
      8'hF3, 8'hF9:
        shape = SH_LEGAL;
      default: shape = 5'd0;
    endcase
  endfunction

  function automatic logic [7:0] get8(logic [2:0] c, logic [7:0] a, regs_t r);
    if (c == 3'd7) get8 = a;
    else if (c < 3'd6) get8 = r[c];
    else get8 = 8'h00;
  endfunction

  function automatic alu_t f_inc(logic [7:0] v, logic [3:0] f);
    logic [7:0] r;
    r = v + 8'd1;
    f_inc = '{r: r, f: {r == 8'h00, 1'b0, v[4] ^ r[4], f[0]}};
  endfunction

  function automatic alu_t f_dec(logic [7:0] v, logic [3:0] f);
    logic [7:0] r;
    r = v - 8'd1;
    f_dec = '{r: r, f: {r == 8'h00, 1'b1, v[4] ^ r[4], f[0]}};
  endfunction

  function automatic alu_t f_add(logic [7:0] a, logic [7:0] b, logic cin);
    logic [8:0] r;
    r = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    f_add = '{r: r[7:0], f: {r[7:0] == 8'h00, 1'b0, a[4] ^ b[4] ^ r[4], r[8]}};
  endfunction

  function automatic alu_t f_sub(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = a - b;
    f_sub = '{r: r, f: {r == 8'h00, 1'b1, a[4] ^ b[4] ^ r[4], b > a}};
  endfunction

  function automatic alu_t f_logic(logic [7:0] r, logic h);
    f_logic = '{r: r, f: {r == 8'h00, 1'b0, h, 1'b0}};
  endfunction

  function automatic alu_t f_rot(logic [7:0] r, logic cout);
    f_rot = '{r: r, f: {r == 8'h00, 1'b0, 1'b0, cout}};
  endfunction

  function automatic alu_t f_daa(logic [7:0] a, logic [3:0] f);
    logic [7:0] v;
    logic [7:0] c;
    logic       cy;
    logic       hadj;
    v = a;
    cy = f[0];
    if (f[2]) begin
      c = (f[1] ? 8'h06 : 8'h00) + (f[0] ? 8'h60 : 8'h00);
      v = v - c;
    end else begin
      hadj = f[0] || (a > 8'h99);
      c = ((f[1] || (a[3:0] > 4'h9)) ? 8'h06 : 8'h00) + (hadj ? 8'h60 : 8'h00);
      cy = hadj;
      v = v + c;
    end
    f_daa = '{r: v, f: {v == 8'h00, f[2], 1'b0, cy}};
  endfunction
endpackage

@@ rtl/sm83_cpu_core_subset_core.sv @@
// SM83 core subset, top level: architectural state, per-transfer step logic and result queue.
// Depends on sm83_pkg and sm83_cpu_core_subset_core_defines.svh.
//
// Each input transfer is executed in the cycle it is accepted and its up to three
// results go into a four-entry result queue and leave one per ready cycle. An input is
// accepted in any cycle in which the queue, after this cycle's output transfer, has
// room for three results, so one item per clock is sustained while the output side
// keeps up. tuser selects start (0) or read data (1). The step path is one pass of
// decode, an 8/16-bit ALU and address adders between the state registers.
`include "sm83_cpu_core_subset_core_defines.svh"
module sm83_cpu_core_subset_core
  import sm83_pkg::*;
#(
  parameter logic [15:0] START_RESET = START_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // start_address
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] read_data
  input  logic        in_tuser,      // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [15:0] bus_address, [23:16] write_byte,
                                     // [24] instr_done, [29:25] instr_cycles, zero pad
  output logic [1:0]  out_tuser,     // [1:0] bus_kind
  output logic        out_tlast      // last
);
  logic [7:0]  a_r, opl_r, lop_r;
  logic [3:0]  f_r;
  regs_t       regs_r;
  logic [15:0] sp_r, pc_r;
  logic        pfx_r, stp_r;
  logic [2:0]  ph_r;

  logic [7:0]  a_nxt, opl_nxt, lop_nxt;
  logic [3:0]  f_nxt;
  regs_t       regs_nxt;
  logic [15:0] sp_nxt, pc_nxt;
  logic        pfx_nxt, stp_nxt;
  logic [2:0]  ph_nxt;

  res_t        rs [3];
  logic [1:0]  nres;

  res_t        q_r [QDEPTH];
  logic [1:0]  rp_r, wp_r;
  logic [2:0]  cnt_r;

  logic        acc, pop;

  assign pop = out_tvalid && out_tready;
  assign in_tready = (cnt_r <= 3'd1) || ((cnt_r == 3'd2) && pop);
  assign acc = in_tvalid && in_tready;

  always_comb begin
    logic [7:0]  d, op, lo, hi;
    logic [15:0] imm, hl, t16;
    logic [16:0] s17;
    logic [4:0]  sh;
    logic        do_op, do_mem, cnd;
    logic [4:0]  cyc;
    alu_t        al;
    d = in_tdata;
    a_nxt = a_r; f_nxt = f_r; regs_nxt = regs_r; sp_nxt = sp_r; pc_nxt = pc_r;
    opl_nxt = opl_r; lop_nxt = lop_r; pfx_nxt = pfx_r; stp_nxt = stp_r; ph_nxt = ph_r;
    nres = 2'd0;
    for (int i = 0; i < 3; i++) rs[i] = '0;
    op = opl_r; lo = 8'h00; hi = 8'h00; do_op = 1'b0; do_mem = 1'b0; cyc = 5'd0;
    sh = 5'd0; imm = 16'h0000; hl = 16'h0000; t16 = 16'h0000; s17 = '0; al = '0;
    cnd = 1'b0;

    if (acc && !stp_r) begin
      if (!in_tuser) begin
        if (ph_r == PH_IDLE) begin
          rs[nres] = '{BK_READ, pc_nxt, 8'h00, 1'b0, 5'd0, 1'b0}; nres = nres + 2'd1;
          pc_nxt = pc_nxt + 16'd1;
          ph_nxt = PH_OPCODE;
        end
      end else begin
        case (ph_r)
          PH_OPCODE: begin
            opl_nxt = d; op = d; pfx_nxt = 1'b0;
            sh = shape(d);
            case (d[4:3])
              2'd0: cnd = !f_r[3];
              2'd1: cnd = f_r[3];
              2'd2: cnd = !f_r[0];
              default: cnd = f_r[0];
            endcase
            if (d == 8'hCB) begin
              pfx_nxt = 1'b1;
              rs[nres] = '{BK_READ, pc_nxt, 8'h00, 1'b0, 5'd0, 1'b0}; nres = nres + 2'd1;
              pc_nxt = pc_nxt + 16'd1;
              ph_nxt = PH_BYTE1;
            end else if (sh == 5'd0) begin
              rs[nres] = '{BK_STOP, pc_nxt - 16'd1, 8'h00, 1'b0, 5'd0, 1'b0};
              nres = nres + 2'd1;
              stp_nxt = 1'b1; ph_nxt = PH_IDLE;
            end else if ((d == 8'hC8 || d == 8'hD0 || d == 8'hD8) && !cnd) begin
              cyc = 5'd8; do_op = 1'b0;
              rs[nres] = '{BK_READ, pc_nxt, 8'h00, 1'b1, cyc, 1'b0}; nres = nres + 2'd1;
              pc_nxt = pc_nxt + 16'd1; ph_nxt = PH_OPCODE;
            end else if (sh[1:0] != 2'd0) begin
              if (sh[2]) begin
                rs[nres] = '{BK_READ, sp_nxt, 8'h00, 1'b0, 5'd0, 1'b0}; nres = nres + 2'd1;
                sp_nxt = sp_nxt + 16'd1;
              end else begin
                rs[nres] = '{BK_READ, pc_nxt, 8'h00, 1'b0, 5'd0, 1'b0}; nres = nres + 2'd1;
                pc_nxt = pc_nxt + 16'd1;
              end
              ph_nxt = PH_BYTE1;
            end else if (sh[3]) begin
              hl = {regs_r[4], regs_r[5]};
              if (d == 8'h1A) t16 = {regs_r[2], regs_r[3]};
              else t16 = hl;
              if (d == 8'h2A) begin
                t16 = hl + 16'd1;
                regs_nxt[4] = t16[15:8]; regs_nxt[5] = t16[7:0];
                t16 = hl;
              end
              rs[nres] = '{BK_READ, t16, 8'h00, 1'b0, 5'd0, 1'b0}; nres = nres + 2'd1;
              ph_nxt = PH_MEM;
            end else begin
              do_op = 1'b1;
            end
          end
          PH_BYTE1: begin
            if (pfx_r) begin
              pfx_nxt = 1'b0;
              cyc = 5'd8;
              case (d)
                8'h11: begin
                  al = f_rot({regs_r[1][6:0], f_r[0]}, regs_r[1][7]);
                  regs_nxt[1] = al.r; f_nxt = al.f;
                end
                8'h19, 8'h1A, 8'h1B: begin
                  al = f_rot({f_r[0], regs_r[d[2:0]][7:1]}, regs_r[d[2:0]][0]);
                  regs_nxt[d[2:0]] = al.r; f_nxt = al.f;
                end
                8'h37: begin
                  al = f_rot({a_r[3:0], a_r[7:4]}, 1'b0);
                  a_nxt = al.r; f_nxt = al.f;
                end
                8'h38: begin
                  al = f_rot({1'b0, regs_r[0][7:1]}, regs_r[0][0]);
                  regs_nxt[0] = al.r; f_nxt = al.f;
                end
                8'h7C: f_nxt = {!regs_r[4][7], 1'b0, 1'b1, f_r[0]};
                default: cyc = 5'd0;
              endcase
              if (cyc == 5'd0) begin
                rs[nres] = '{BK_STOP, pc_nxt - 16'd1, 8'h00, 1'b0, 5'd0, 1'b0};
                nres = nres + 2'd1;
                stp_nxt = 1'b1; ph_nxt = PH_IDLE;
              end else begin
                rs[nres] = '{BK_READ, pc_nxt, 8'h00, 1'b1, cyc, 1'b0}; nres = nres + 2'd1;
                pc_nxt = pc_nxt + 16'd1; ph_nxt = PH_OPCODE;
              end
            end else begin
              sh = shape(opl_r);
              lop_nxt = d;
              if (sh[1:0] == 2'd2) begin
                if (sh[2]) begin
                  rs[nres] = '{BK_READ, sp_nxt, 8'h00, 1'b0, 5'd0, 1'b0}; nres = nres + 2'd1;
                  sp_nxt = sp_nxt + 16'd1;
                end else begin
                  rs[nres] = '{BK_READ, pc_nxt, 8'h00, 1'b0, 5'd0, 1'b0}; nres = nres + 2'd1;
                  pc_nxt = pc_nxt + 16'd1;
                end
                ph_nxt = PH_BYTE2;
              end else if (sh[3]) begin
                rs[nres] = '{BK_READ, {8'hFF, d}, 8'h00, 1'b0, 5'd0, 1'b0};
                nres = nres + 2'd1;
                ph_nxt = PH_MEM;
              end else begin
                do_op = 1'b1; lo = d;
              end
            end
          end
          PH_BYTE2: begin
            sh = shape(opl_r);
            if (sh[3]) begin
              rs[nres] = '{BK_READ, {d, lop_r}, 8'h00, 1'b0, 5'd0, 1'b0};
              nres = nres + 2'd1;
              ph_nxt = PH_MEM;
            end else begin
              do_op = 1'b1; lo = lop_r; hi = d;
            end
          end
          PH_MEM: begin
            do_mem = 1'b1;
          end
          default: ;
        endcase
      end
    end

    if (do_mem) begin
      hl = {regs_r[4], regs_r[5]};
      cyc = 5'd8;
      case (op)
        8'h35: begin
          al = f_dec(d, f_r); f_nxt = al.f;
          rs[nres] = '{BK_WRITE, hl, al.r, 1'b0, 5'd0, 1'b0}; nres = nres + 2'd1;
          cyc = 5'd12;
        end
        8'h86: begin al = f_add(a_r, d, 1'b0); a_nxt = al.r; f_nxt = al.f; end
        8'hAE: begin al = f_logic(a_r ^ d, 1'b0); a_nxt = al.r; f_nxt = al.f; end
        8'hB6: begin al = f_logic(a_r | d, 1'b0); a_nxt = al.r; f_nxt = al.f; end
        8'hBE: begin al = f_sub(a_r, d); f_nxt = al.f; end
        8'hF0: begin a_nxt = d; cyc = 5'd12; end
        8'hFA: begin a_nxt = d; cyc = 5'd16; end
        8'h1A, 8'h2A, 8'h7E: a_nxt = d;
        default: begin
          if (op[5:3] == 3'd7) a_nxt = d;
          else if (op[5:3] < 3'd6) regs_nxt[op[5:3]] = d;
        end
      endcase
      rs[nres] = '{BK_READ, pc_nxt, 8'h00, 1'b1, cyc, 1'b0}; nres = nres + 2'd1;
      pc_nxt = pc_nxt + 16'd1; ph_nxt = PH_OPCODE;
    end

    if (do_op) begin
      imm = {hi, lo};
      hl = {regs_r[4], regs_r[5]};
      case (op[4:3])
        2'd0: cnd = !f_r[3];
        2'd1: cnd = f_r[3];
        2'd2: cnd = !f_r[0];
        default: cnd = f_r[0];
      endcase
      cyc = 5'd4;
      case (op)
        8'h01, 8'h11, 8'h21: begin
          regs_nxt[{op[5:4], 1'b0}] = hi; regs_nxt[{op[5:4], 1'b1}] = lo; cyc = 5'd12;
        end
        8'h31: begin sp_nxt = imm; cyc = 5'd12; end
        8'h03, 8'h13, 8'h23: begin
          t16 = {regs_r[{op[5:4], 1'b0}], regs_r[{op[5:4], 1'b1}]} + 16'd1;
          regs_nxt[{op[5:4], 1'b0}] = t16[15:8]; regs_nxt[{op[5:4], 1'b1}] = t16[7:0];
          cyc = 5'd8;
        end
        8'h33: begin sp_nxt = sp_r + 16'd1; cyc = 5'd8; end
        8'h3B: begin sp_nxt = sp_r - 16'd1; cyc = 5'd8; end
        8'h04, 8'h0C, 8'h14, 8'h1C, 8'h24, 8'h2C, 8'h3C: begin
          al = f_inc(get8(op[5:3], a_r, regs_r), f_r); f_nxt = al.f;
          if (op[5:3] == 3'd7) a_nxt = al.r; else regs_nxt[op[5:3]] = al.r;
        end
        8'h05, 8'h0D, 8'h15, 8'h1D, 8'h25, 8'h2D, 8'h3D: begin
          al = f_dec(get8(op[5:3], a_r, regs_r), f_r); f_nxt = al.f;
          if (op[5:3] == 3'd7) a_nxt = al.r; else regs_nxt[op[5:3]] = al.r;
        end
        8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h3E: begin
          if (op[5:3] == 3'd7) a_nxt = lo; else regs_nxt[op[5:3]] = lo;
          cyc = 5'd8;
        end
        8'h08: begin
          rs[nres] = '{BK_WRITE, imm, sp_r[7:0], 1'b0, 5'd0, 1'b0}; nres = nres + 2'd1;
          rs[nres] = '{BK_WRITE, imm + 16'd1, sp_r[15:8], 1'b0, 5'd0, 1'b0};
          nres = nres + 2'd1;
          cyc = 5'd20;
        end
        8'h12: begin
          rs[nres] = '{BK_WRITE, {regs_r[2], regs_r[3]}, a_r, 1'b0, 5'd0, 1'b0};
          nres = nres + 2'd1; cyc = 5'd8;
        end
        8'h22, 8'h32: begin
          rs[nres] = '{BK_WRITE, hl, a_r, 1'b0, 5'd0, 1'b0}; nres = nres + 2'd1;
          t16 = op[4] ? hl - 16'd1 : hl + 16'd1;
          regs_nxt[4] = t16[15:8]; regs_nxt[5] = t16[7:0]; cyc = 5'd8;
        end
        8'h70, 8'h71, 8'h72, 8'h73, 8'h77: begin
          rs[nres] = '{BK_WRITE, hl, get8(op[2:0], a_r, regs_r), 1'b0, 5'd0, 1'b0};
          nres = nres + 2'd1; cyc = 5'd8;
        end
        8'hE2: begin
          rs[nres] = '{BK_WRITE, {8'hFF, regs_r[1]}, a_r, 1'b0, 5'd0, 1'b0};
          nres = nres + 2'd1; cyc = 5'd8;
        end
        8'hE0: begin
          rs[nres] = '{BK_WRITE, {8'hFF, lo}, a_r, 1'b0, 5'd0, 1'b0};
          nres = nres + 2'd1; cyc = 5'd12;
        end
        8'hEA: begin
          rs[nres] = '{BK_WRITE, imm, a_r, 1'b0, 5'd0, 1'b0}; nres = nres + 2'd1;
          cyc = 5'd16;
        end
        8'h17: begin a_nxt = {a_r[6:0], f_r[0]}; f_nxt = {3'b000, a_r[7]}; end
        8'h1F: begin a_nxt = {f_r[0], a_r[7:1]}; f_nxt = {3'b000, a_r[0]}; end
        8'h18, 8'h20, 8'h28, 8'h30, 8'h38: begin
          if (op != 8'h18 && !cnd) cyc = 5'd8;
          else begin
            pc_nxt = pc_nxt + {{8{lo[7]}}, lo}; cyc = 5'd12;
          end
        end
        8'h27: begin al = f_daa(a_r, f_r); a_nxt = al.r; f_nxt = al.f; end
        8'h29, 8'h39: begin
          t16 = op[4] ? sp_r : hl;
          s17 = {1'b0, hl} + {1'b0, t16};
          f_nxt = {f_r[3], 1'b0, (({1'b0, hl[11:0]} + {1'b0, t16[11:0]}) > 13'h0FFF), s17[16]};
          regs_nxt[4] = s17[15:8]; regs_nxt[5] = s17[7:0]; cyc = 5'd8;
        end
        8'h80: begin al = f_add(a_r, regs_r[0], 1'b0); a_nxt = al.r; f_nxt = al.f; end
        8'h90: begin al = f_sub(a_r, regs_r[0]); a_nxt = al.r; f_nxt = al.f; end
        8'hA9, 8'hAD, 8'hAF: begin
          al = f_logic(a_r ^ get8(op[2:0], a_r, regs_r), 1'b0); a_nxt = al.r; f_nxt = al.f;
        end
        8'hB0, 8'hB1, 8'hB7: begin
          al = f_logic(a_r | get8(op[2:0], a_r, regs_r), 1'b0); a_nxt = al.r; f_nxt = al.f;
        end
        8'hB8, 8'hB9, 8'hBA, 8'hBB: begin
          al = f_sub(a_r, get8(op[2:0], a_r, regs_r)); f_nxt = al.f;
        end
        8'hC1, 8'hD1, 8'hE1: begin
          regs_nxt[{op[5:4], 1'b0}] = hi; regs_nxt[{op[5:4], 1'b1}] = lo; cyc = 5'd12;
        end
        8'hF1: begin f_nxt = lo[7:4]; a_nxt = hi; cyc = 5'd12; end
        8'hC2: begin
          if (!cnd) cyc = 5'd12; else begin pc_nxt = imm; cyc = 5'd16; end
        end
        8'hC3: begin pc_nxt = imm; cyc = 5'd16; end
        8'hC4, 8'hCD: begin
          if (op == 8'hC4 && !cnd) cyc = 5'd12;
          else begin
            rs[nres] = '{BK_WRITE, sp_r - 16'd1, pc_r[15:8], 1'b0, 5'd0, 1'b0};
            nres = nres + 2'd1;
            rs[nres] = '{BK_WRITE, sp_r - 16'd2, pc_r[7:0], 1'b0, 5'd0, 1'b0};
            nres = nres + 2'd1;
            sp_nxt = sp_r - 16'd2; pc_nxt = imm; cyc = 5'd24;
          end
        end
        8'hC5, 8'hD5, 8'hE5, 8'hF5: begin
          if (op == 8'hF5) t16 = {a_r, f_r, 4'h0};
          else t16 = {regs_r[{op[5:4], 1'b0}], regs_r[{op[5:4], 1'b1}]};
          rs[nres] = '{BK_WRITE, sp_r - 16'd1, t16[15:8], 1'b0, 5'd0, 1'b0};
          nres = nres + 2'd1;
          rs[nres] = '{BK_WRITE, sp_r - 16'd2, t16[7:0], 1'b0, 5'd0, 1'b0};
          nres = nres + 2'd1;
          sp_nxt = sp_r - 16'd2; cyc = 5'd16;
        end
        8'hC6: begin al = f_add(a_r, lo, 1'b0); a_nxt = al.r; f_nxt = al.f; cyc = 5'd8; end
        8'hCE: begin al = f_add(a_r, lo, f_r[0]); a_nxt = al.r; f_nxt = al.f; cyc = 5'd8; end
        8'hD6: begin al = f_sub(a_r, lo); a_nxt = al.r; f_nxt = al.f; cyc = 5'd8; end
        8'hE6: begin al = f_logic(a_r & lo, 1'b1); a_nxt = al.r; f_nxt = al.f; cyc = 5'd8; end
        8'hEE: begin al = f_logic(a_r ^ lo, 1'b0); a_nxt = al.r; f_nxt = al.f; cyc = 5'd8; end
        8'hFE: begin al = f_sub(a_r, lo); f_nxt = al.f; cyc = 5'd8; end
        8'hC8, 8'hD0, 8'hD8: begin pc_nxt = imm; cyc = 5'd20; end
        8'hC9: begin pc_nxt = imm; cyc = 5'd16; end
        8'hE8, 8'hF8: begin
          t16 = sp_r + {{8{lo[7]}}, lo};
          f_nxt = {2'b00, sp_r[4] ^ lo[4] ^ t16[4],
                   (({1'b0, sp_r[7:0]} + {1'b0, lo}) > 9'h0FF)};
          if (op == 8'hE8) begin sp_nxt = t16; cyc = 5'd16; end
          else begin regs_nxt[4] = t16[15:8]; regs_nxt[5] = t16[7:0]; cyc = 5'd12; end
        end
        8'hE9: pc_nxt = hl;
        8'hF9: begin sp_nxt = hl; cyc = 5'd8; end
        default: begin
          if (op[7:6] == 2'b01) begin
            if (op[5:3] == 3'd7) a_nxt = get8(op[2:0], a_r, regs_r);
            else if (op[5:3] < 3'd6) regs_nxt[op[5:3]] = get8(op[2:0], a_r, regs_r);
          end
        end
      endcase
      rs[nres] = '{BK_READ, pc_nxt, 8'h00, 1'b1, cyc, 1'b0}; nres = nres + 2'd1;
      pc_nxt = pc_nxt + 16'd1; ph_nxt = PH_OPCODE;
    end

    if (nres != 2'd0) rs[nres - 2'd1].last = 1'b1;

    if (cfg_wr_en && ph_nxt == PH_IDLE && !stp_nxt) pc_nxt = cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0; f_r <= '0; regs_r <= '0; sp_r <= '0; pc_r <= START_RESET;
      opl_r <= '0; lop_r <= '0; pfx_r <= 1'b0; stp_r <= 1'b0; ph_r <= PH_IDLE;
      rp_r <= '0; wp_r <= '0; cnt_r <= '0;
    end else begin
      a_r <= a_nxt; f_r <= f_nxt; regs_r <= regs_nxt; sp_r <= sp_nxt; pc_r <= pc_nxt;
      opl_r <= opl_nxt; lop_r <= lop_nxt; pfx_r <= pfx_nxt; stp_r <= stp_nxt;
      ph_r <= ph_nxt;
      wp_r <= wp_r + nres;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, nres} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < nres) q_r[wp_r + 2'(i)] <= rs[i];
    end
  end

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {2'b00, q_r[rp_r].cyc, q_r[rp_r].done, q_r[rp_r].wbyte,
                       q_r[rp_r].addr};
  assign out_tuser  = q_r[rp_r].kind;
  assign out_tlast  = q_r[rp_r].last;

  `SM_ASSERT(a_qcnt, cnt_r <= 3'(QDEPTH))
  `SM_ASSERT(a_room, !in_tready || (cnt_r <= 3'd2))
  `SM_ASSERT(a_stop_idle, !stp_r || (ph_r == PH_IDLE))
  `SM_ASSERT_NEXT(a_stop_sticky, stp_r, stp_r && (pc_r == $past(pc_r)))
endmodule
